[design/acis_pkg.sv]
// Shared types, codes and character helpers for the ASCII integer scanner.
// Used by acis_core and ascii_integer_scanner; depends on nothing else.
package acis_pkg;

    // Fixed field widths of the ports
    localparam int VALUE_W  = 32;
    localparam int STATUS_W = 2;
    localparam int LEN_W    = 10;
    localparam int CONV_W   = 3;
    localparam int MAXW_W   = 10;
    localparam int SIZE_W   = 2;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DAT_W = 10;
    localparam int PHASE_W  = 3;
    localparam int RADIX_W  = 5;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_CONVERSION = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_WIDTH  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SIZE_MODE  = 2'd2;

    // Conversion codes
    localparam logic [CONV_W-1:0] CONV_SDEC = 3'd0;
    localparam logic [CONV_W-1:0] CONV_GEN  = 3'd1;
    localparam logic [CONV_W-1:0] CONV_UDEC = 3'd2;
    localparam logic [CONV_W-1:0] CONV_OCT  = 3'd3;
    localparam logic [CONV_W-1:0] CONV_HEX  = 3'd4;
    localparam logic [CONV_W-1:0] CONV_BIN  = 3'd5;

    // Size codes
    localparam logic [SIZE_W-1:0] SIZE_SHORT = 2'd0;
    localparam logic [SIZE_W-1:0] SIZE_INT   = 2'd1;
    localparam logic [SIZE_W-1:0] SIZE_LONG  = 2'd2;

    // Result status codes
    localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
    localparam logic [STATUS_W-1:0] ST_NOMATCH = 2'd1;
    localparam logic [STATUS_W-1:0] ST_EOF     = 2'd2;

    // Scanner phases
    localparam logic [PHASE_W-1:0] PH_SKIP = 3'd0;
    localparam logic [PHASE_W-1:0] PH_SIGN = 3'd1;
    localparam logic [PHASE_W-1:0] PH_ZERO = 3'd2;
    localparam logic [PHASE_W-1:0] PH_X    = 3'd3;
    localparam logic [PHASE_W-1:0] PH_DIG  = 3'd4;

    // Radix values
    localparam logic [RADIX_W-1:0] RADIX_2  = 5'd2;
    localparam logic [RADIX_W-1:0] RADIX_8  = 5'd8;
    localparam logic [RADIX_W-1:0] RADIX_10 = 5'd10;
    localparam logic [RADIX_W-1:0] RADIX_16 = 5'd16;

    // Characters
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_0     = 8'h30;
    localparam logic [7:0] CH_9     = 8'h39;
    localparam logic [7:0] CH_UA    = 8'h41;
    localparam logic [7:0] CH_UF    = 8'h46;
    localparam logic [7:0] CH_UX    = 8'h58;
    localparam logic [7:0] CH_LA    = 8'h61;
    localparam logic [7:0] CH_LF    = 8'h66;
    localparam logic [7:0] CH_LX    = 8'h78;

    typedef struct packed {
        logic [CONV_W-1:0] conversion;
        logic [MAXW_W-1:0] max_width;
        logic [SIZE_W-1:0] size_mode;
    } cfg_t;

    typedef struct packed {
        logic [VALUE_W-1:0]  value;
        logic [STATUS_W-1:0] status;
        logic                saturated;
        logic [LEN_W-1:0]    token_length;
        logic                byte_returned;
    } res_t;

    typedef struct packed {
        logic       valid;
        logic [3:0] val;
    } digit_t;

    // Hex digit decode, both letter cases
    function automatic digit_t digit_of(input logic [7:0] b);
        digit_t d;
        d.valid = 1'b1;
        d.val   = 4'd0;
        if (b >= CH_0 && b <= CH_9) begin
            d.val = 4'(b - CH_0);
        end
        else if (b >= CH_LA && b <= CH_LF) begin
            d.val = 4'(b - CH_LA + 8'd10);
        end
        else if (b >= CH_UA && b <= CH_UF) begin
            d.val = 4'(b - CH_UA + 8'd10);
        end
        else begin
            d.valid = 1'b0;
        end
        return d;
    endfunction

    // Space, tab, LF, VT, FF, CR
    function automatic logic is_space(input logic [7:0] b);
        return (b == CH_SPACE) || (b >= CH_TAB && b <= CH_CR);
    endfunction

    // Starting radix of a conversion; general mode starts as hex
    function automatic logic [RADIX_W-1:0] base_of(input logic [CONV_W-1:0] c);
        logic [RADIX_W-1:0] r;
        unique case (c)
            CONV_GEN, CONV_HEX: r = RADIX_16;
            CONV_OCT:           r = RADIX_8;
            CONV_BIN:           r = RADIX_2;
            default:            r = RADIX_10;
        endcase
        return r;
    endfunction

endpackage

[design/acis_core.sv]
// Token state and per-byte scan step: classify, multiply-accumulate, finish.
// Depends on acis_pkg.
module acis_core #(
    parameter int VALUE_BITS = 32,
    parameter int MAX_TOKEN  = 512
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           fire,
    input  logic [7:0]     text_byte,
    input  logic           end_of_input,
    input  acis_pkg::cfg_t cfg,
    output logic           emit,
    output acis_pkg::res_t res
);
    import acis_pkg::*;

    localparam int VB     = VALUE_BITS;
    localparam int AW     = VB + 4;
    localparam int WL_W   = $clog2(MAX_TOKEN + 1);
    localparam int CMP_W  = (WL_W > MAXW_W) ? WL_W : MAXW_W;
    localparam int INT_BITS = (VB < 32) ? VB : 32;

    localparam logic [VB-1:0] HALF    = {1'b1, {(VB-1){1'b0}}};
    localparam logic [VB-1:0] HALF_M1 = {1'b0, {(VB-1){1'b1}}};
    localparam logic [VB-1:0] UMAX    = {VB{1'b1}};
    localparam logic [VB-1:0] MASK16  = VB'({16{1'b1}});
    localparam logic [VB-1:0] MASKINT = VB'({INT_BITS{1'b1}});

    logic [PHASE_W-1:0] phase_reg, phase_next;
    logic [WL_W-1:0]    wl_reg, wl_next;
    logic [RADIX_W-1:0] radix_reg, radix_next;
    logic               neg_reg, neg_next;
    logic [VB-1:0]      acc_reg, acc_next;
    logic               ovf_reg, ovf_next;
    logic [WL_W-1:0]    cnt_reg, cnt_next;
    logic               ds_reg, ds_next;
    logic [CONV_W-1:0]  tc_reg, tc_next;

    // State update only when the step fires
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_SKIP;
            wl_reg    <= '0;
            radix_reg <= RADIX_10;
            neg_reg   <= 1'b0;
            acc_reg   <= '0;
            ovf_reg   <= 1'b0;
            cnt_reg   <= '0;
            ds_reg    <= 1'b0;
            tc_reg    <= CONV_SDEC;
        end
        else if (fire)
        begin
            phase_reg <= phase_next;
            wl_reg    <= wl_next;
            radix_reg <= radix_next;
            neg_reg   <= neg_next;
            acc_reg   <= acc_next;
            ovf_reg   <= ovf_next;
            cnt_reg   <= cnt_next;
            ds_reg    <= ds_next;
            tc_reg    <= tc_next;
        end
    end

    // One byte through the phase chain
    always_comb
    begin
        logic          run;
        logic          do_take;
        logic          do_finish;
        logic          fin_ret;
        digit_t        dig;
        logic [AW-1:0] acc_w;
        logic [AW-1:0] prod;
        logic [AW-1:0] wide;
        logic [VB-1:0] val;
        logic [VB-1:0] neg_acc;
        logic [VB-1:0] mask;
        logic          sat;

        phase_next = phase_reg;
        wl_next    = wl_reg;
        radix_next = radix_reg;
        neg_next   = neg_reg;
        acc_next   = acc_reg;
        ovf_next   = ovf_reg;
        cnt_next   = cnt_reg;
        ds_next    = ds_reg;
        tc_next    = tc_reg;

        run       = 1'b0;
        do_take   = 1'b0;
        do_finish = 1'b0;
        fin_ret   = 1'b0;
        dig       = digit_of(text_byte);
        acc_w     = '0;
        prod      = '0;
        wide      = '0;
        val       = '0;
        neg_acc   = '0;
        mask      = '0;
        sat       = 1'b0;

        emit = 1'b0;
        res  = '0;

        if (end_of_input)
        begin
            if (phase_reg == PH_SKIP)
            begin
                emit       = 1'b1;
                res.status = ST_EOF;
            end
            else
            begin
                do_finish = 1'b1;
            end
        end
        else
        begin
            run = 1'b1;
            // Token start: latch conversion and width
            if (phase_reg == PH_SKIP)
            begin
                if (is_space(text_byte))
                begin
                    run = 1'b0;
                end
                else
                begin
                    tc_next    = (cfg.conversion > CONV_BIN) ? CONV_SDEC : cfg.conversion;
                    radix_next = base_of(tc_next);
                    neg_next   = 1'b0;
                    acc_next   = '0;
                    ovf_next   = 1'b0;
                    cnt_next   = '0;
                    ds_next    = 1'b0;
                    if (CMP_W'(cfg.max_width) > CMP_W'(MAX_TOKEN))
                        wl_next = WL_W'(MAX_TOKEN);
                    else
                        wl_next = WL_W'(cfg.max_width);
                    if (wl_next == '0)
                    begin
                        emit              = 1'b1;
                        res.status        = ST_NOMATCH;
                        res.byte_returned = 1'b1;
                        run               = 1'b0;
                    end
                    else
                    begin
                        phase_next = PH_SIGN;
                    end
                end
            end

            if (run)
            begin
                // Optional sign
                if (phase_next == PH_SIGN)
                begin
                    if (text_byte == CH_PLUS || text_byte == CH_MINUS)
                    begin
                        neg_next   = (text_byte == CH_MINUS);
                        phase_next = PH_ZERO;
                        do_take    = 1'b1;
                    end
                    else
                    begin
                        phase_next = PH_ZERO;
                    end
                end
                // Leading zero of a hex prefix
                if (phase_next == PH_ZERO && !do_take)
                begin
                    if (radix_next == RADIX_16 && text_byte == CH_0)
                    begin
                        ds_next    = 1'b1;
                        phase_next = PH_X;
                        do_take    = 1'b1;
                    end
                    else
                    begin
                        if (tc_next == CONV_GEN)
                            radix_next = RADIX_10;
                        phase_next = PH_DIG;
                    end
                end
                // x or X after the zero
                if (phase_next == PH_X && !do_take)
                begin
                    phase_next = PH_DIG;
                    if (text_byte == CH_LX || text_byte == CH_UX)
                        do_take = 1'b1;
                    else if (tc_next == CONV_GEN)
                        radix_next = RADIX_8;
                end
                // Digits: saturating multiply-accumulate
                if (phase_next == PH_DIG && !do_take)
                begin
                    if (!dig.valid || RADIX_W'(dig.val) >= radix_next)
                    begin
                        do_finish = 1'b1;
                        fin_ret   = 1'b1;
                    end
                    else
                    begin
                        acc_w = AW'(acc_next);
                        case (radix_next)
                            RADIX_2:  prod = acc_w << 1;
                            RADIX_8:  prod = acc_w << 3;
                            RADIX_16: prod = acc_w << 4;
                            default:  prod = (acc_w << 3) + (acc_w << 1);
                        endcase
                        wide = prod + AW'(dig.val);
                        if (!ovf_next)
                        begin
                            if (|wide[AW-1:VB])
                                ovf_next = 1'b1;
                            else
                                acc_next = wide[VB-1:0];
                        end
                        ds_next = 1'b1;
                        do_take = 1'b1;
                    end
                end
            end

            // Byte taken into the token; width may run out
            if (do_take)
            begin
                cnt_next = cnt_next + WL_W'(1);
                wl_next  = wl_next - WL_W'(1);
                if (wl_next == '0)
                    do_finish = 1'b1;
            end
        end

        // Token end: clamp, negate, truncate to size
        if (do_finish)
        begin
            phase_next        = PH_SKIP;
            emit              = 1'b1;
            res.token_length  = LEN_W'(cnt_next);
            res.byte_returned = fin_ret;
            if (!ds_next)
            begin
                res.status = ST_NOMATCH;
            end
            else
            begin
                neg_acc = UMAX & (VB'(0) - acc_next);
                if (tc_next == CONV_SDEC || tc_next == CONV_GEN)
                begin
                    if (neg_next)
                    begin
                        if (ovf_next || acc_next > HALF)
                        begin
                            val = HALF;
                            sat = 1'b1;
                        end
                        else
                            val = neg_acc;
                    end
                    else
                    begin
                        if (ovf_next || acc_next > HALF_M1)
                        begin
                            val = HALF_M1;
                            sat = 1'b1;
                        end
                        else
                            val = acc_next;
                    end
                end
                else
                begin
                    if (ovf_next)
                    begin
                        val = UMAX;
                        sat = 1'b1;
                    end
                    else
                        val = neg_next ? neg_acc : acc_next;
                end
                unique case (cfg.size_mode)
                    SIZE_SHORT: mask = MASK16;
                    SIZE_INT:   mask = MASKINT;
                    default:    mask = UMAX;
                endcase
                res.status    = ST_OK;
                res.saturated = sat;
                res.value     = VALUE_W'(val & mask);
            end
        end
    end

endmodule

[design/ascii_integer_scanner.sv]
// Top level of the ASCII integer scanner: input register, scan core, result
// register and configuration registers. Depends on acis_pkg and acis_core.
//
//   channel  direction  handshake            payload
//   in       to block   in_valid / in_stall   text_byte, end_of_input
//   out      from block out_valid / out_stall value, status, saturated,
//                                             token_length, byte_returned
//   cfg      to block   cfg_valid / cfg_ready cfg_index, cfg_data
//
// One byte per cycle sustained while out_stall is low. A request is scanned while
// it sits in the input register; a result, made at token end or end of input, is
// written to the output register as that byte leaves the input register. Reset
// returns to whitespace skipping with conversion 0, max_width 512, size_mode 1. A
// stalled result holds the output register; one more byte is taken into the input
// register, then in_stall rises until the result leaves. cfg_ready is always high.
module ascii_integer_scanner #(
    parameter int VALUE_BITS = 32,
    parameter int MAX_TOKEN  = 512
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_stall,
    input  logic [7:0]                      text_byte,
    input  logic                            end_of_input,
    output logic                            out_valid,
    input  logic                            out_stall,
    output logic [acis_pkg::VALUE_W-1:0]    value,
    output logic [acis_pkg::STATUS_W-1:0]   status,
    output logic                            saturated,
    output logic [acis_pkg::LEN_W-1:0]      token_length,
    output logic                            byte_returned,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [acis_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [acis_pkg::CFG_DAT_W-1:0]  cfg_data
);
    import acis_pkg::*;

    logic       in_valid_reg, in_valid_next;
    logic [7:0] in_byte_reg;
    logic       in_eoi_reg;
    logic       out_valid_reg, out_valid_next;
    res_t       out_res_reg;
    cfg_t       cfg_reg;

    logic       out_free;
    logic       fire;
    logic       accept_in;
    logic       emit;
    res_t       res;

    // Handshake control
    assign out_free      = !out_valid_reg || !out_stall;
    assign fire          = in_valid_reg && out_free;
    assign in_stall      = in_valid_reg && !out_free;
    assign accept_in     = in_valid && !in_stall;
    assign in_valid_next = accept_in || (in_valid_reg && !fire);
    assign out_valid_next = (fire && emit) || (out_valid_reg && out_stall);
    assign cfg_ready     = 1'b1;

    // Input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else
            in_valid_reg <= in_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (accept_in)
        begin
            in_byte_reg <= text_byte;
            in_eoi_reg  <= end_of_input;
        end
    end

    // Result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (fire && emit)
            out_res_reg <= res;
    end

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.conversion <= CONV_SDEC;
            cfg_reg.max_width  <= MAXW_W'(512);
            cfg_reg.size_mode  <= SIZE_INT;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                CFG_CONVERSION: cfg_reg.conversion <= cfg_data[CONV_W-1:0];
                CFG_MAX_WIDTH:  cfg_reg.max_width  <= cfg_data[MAXW_W-1:0];
                CFG_SIZE_MODE:  cfg_reg.size_mode  <= cfg_data[SIZE_W-1:0];
                default:        ;
            endcase
        end
    end

    acis_core #(
        .VALUE_BITS (VALUE_BITS),
        .MAX_TOKEN  (MAX_TOKEN)
    ) u_core (
        .clk          (clk),
        .rst_n        (rst_n),
        .fire         (fire),
        .text_byte    (in_byte_reg),
        .end_of_input (in_eoi_reg),
        .cfg          (cfg_reg),
        .emit         (emit),
        .res          (res)
    );

    assign out_valid     = out_valid_reg;
    assign value         = out_res_reg.value;
    assign status        = out_res_reg.status;
    assign saturated     = out_res_reg.saturated;
    assign token_length  = out_res_reg.token_length;
    assign byte_returned = out_res_reg.byte_returned;

endmodule
